### hdl/rri_pkg.sv
// Shared types, widths and constants for the ray / rectangle intersection core.
// No dependencies.
package rri_pkg;

  localparam int COORD_W   = 20;
  localparam int T_W       = 32;
  localparam int T_FRAC    = 16;
  localparam int CFG_W     = 60;
  localparam int LEN_W     = 40;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W = COORD_W + 1;
  localparam int DEN_W  = 2 * COORD_W + 2;
  localparam int NUM_W  = 2 * COORD_W + 3;

  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = T_W / DIV_STEPS;

  localparam int FIFO_DEPTH = 32;

  localparam logic signed [T_W-1:0] EPS_T =
    T_W'(((64'd1 << T_FRAC) + 64'd5000) / 64'd10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER = 3'd0,
    REG_EDGE_A = 3'd1,
    REG_EDGE_B = 3'd2,
    REG_NORMAL = 3'd3,
    REG_LEN_A  = 3'd4,
    REG_LEN_B  = 3'd5
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0]   vec3_t;   // element 0 is x

  typedef struct packed {
    logic                  mode;
    coord_t                origin_x;
    coord_t                origin_y;
    coord_t                origin_z;
    coord_t                dir_x;
    coord_t                dir_y;
    coord_t                dir_z;
    logic signed [T_W-1:0] t_lower;
    logic signed [T_W-1:0] t_upper;
  } in_word_t;

  typedef struct packed {
    logic                  hit;
    logic signed [T_W-1:0] hit_t;
    coord_t                point_x;
    coord_t                point_y;
    coord_t                point_z;
  } out_word_t;

  typedef struct packed {
    vec3_t            corner;
    vec3_t            edge_a;
    vec3_t            edge_b;
    vec3_t            normal;
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
  } cfg_t;

  typedef struct packed {
    logic                  miss;
    logic                  mode;
    logic                  neg;
    logic                  sat;
    vec3_t                 origin;
    vec3_t                 dir;
    logic signed [T_W-1:0] t_lower;
    logic signed [T_W-1:0] t_upper;
  } div_side_t;

  typedef struct packed {
    div_side_t        side;
    logic [DEN_W-1:0] d;
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] r;
    logic [T_W-1:0]   q;
  } div_word_t;

endpackage

### hdl/rri_front.sv
// Front end: plane distance, dot products, signs and magnitudes for the divider.
// Depends on rri_pkg.
module rri_front (
  input  logic              clk,
  input  logic              rst,
  input  rri_pkg::cfg_t     cfg,
  input  logic              in_v,
  input  rri_pkg::in_word_t in_w,
  output logic              out_v,
  output rri_pkg::div_word_t out_w
);
  import rri_pkg::*;

  localparam int PD_W  = 2 * COORD_W;
  localparam int PN_W  = 2 * COORD_W + 1;
  localparam int CMP_W = DEN_W + T_W;

  vec3_t in_o, in_d;
  assign in_o = {in_w.origin_z, in_w.origin_y, in_w.origin_x};
  assign in_d = {in_w.dir_z, in_w.dir_y, in_w.dir_x};

  logic                      a_v;
  in_word_t                  a_w;
  vec3_t                     a_o, a_d;
  logic signed [DIFF_W-1:0]  a_diff [3];

  logic                      b_v;
  in_word_t                  b_w;
  vec3_t                     b_o, b_d;
  logic signed [PD_W-1:0]    b_den_p [3];
  logic signed [PN_W-1:0]    b_num_p [3];

  logic                      c_v;
  in_word_t                  c_w;
  vec3_t                     c_o, c_d;
  logic signed [DEN_W-1:0]   c_den;
  logic signed [NUM_W-1:0]   c_num;

  logic [NUM_W-1:0] n_mag;
  logic [DEN_W-1:0] d_mag;
  logic             sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      a_v <= in_v;
      b_v <= a_v;
      c_v <= b_v;
    end
    a_w <= in_w;
    a_o <= in_o;
    a_d <= in_d;
    for (int i = 0; i < 3; i++) begin
      a_diff[i] <= DIFF_W'($signed(cfg.corner[i])) - DIFF_W'($signed(in_o[i]));
    end
    b_w <= a_w;
    b_o <= a_o;
    b_d <= a_d;
    for (int i = 0; i < 3; i++) begin
      b_den_p[i] <= PD_W'($signed(a_d[i])) * PD_W'($signed(cfg.normal[i]));
      b_num_p[i] <= PN_W'(a_diff[i]) * PN_W'($signed(cfg.normal[i]));
    end
    c_w   <= b_w;
    c_o   <= b_o;
    c_d   <= b_d;
    c_den <= DEN_W'(b_den_p[0]) + DEN_W'(b_den_p[1]) + DEN_W'(b_den_p[2]);
    c_num <= NUM_W'(b_num_p[0]) + NUM_W'(b_num_p[1]) + NUM_W'(b_num_p[2]);
  end

  always_comb begin
    n_mag = c_num[NUM_W-1] ? NUM_W'(-c_num) : NUM_W'(c_num);
    d_mag = c_den[DEN_W-1] ? DEN_W'(-c_den) : DEN_W'(c_den);
    // integer part of |t| would not fit: saturate
    sat = CMP_W'(n_mag) >= (CMP_W'(d_mag) << (T_W - 1 - T_FRAC));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= c_v;
    end
    out_w.side.miss    <= (c_den == '0) || (!c_w.mode && (c_den > 0));
    out_w.side.mode    <= c_w.mode;
    out_w.side.neg     <= c_num[NUM_W-1] ^ c_den[DEN_W-1];
    out_w.side.sat     <= sat;
    out_w.side.origin  <= c_o;
    out_w.side.dir     <= c_d;
    out_w.side.t_lower <= c_w.t_lower;
    out_w.side.t_upper <= c_w.t_upper;
    out_w.d <= d_mag;
    out_w.n <= n_mag;
    out_w.r <= DEN_W'(n_mag >> (T_W - T_FRAC));
    out_w.q <= '0;
  end

endmodule

### hdl/rri_div_stage.sv
// One stage of the restoring divider: DIV_STEPS quotient bits per stage.
// Depends on rri_pkg.
module rri_div_stage #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_v,
  input  rri_pkg::div_word_t in_w,
  output logic               out_v,
  output rri_pkg::div_word_t out_w
);
  import rri_pkg::*;

  div_word_t w;

  always_comb begin
    int           k;
    logic         nb;
    logic [DEN_W:0] trial;
    w = in_w;
    for (int j = 0; j < DIV_STEPS; j++) begin
      k  = T_W - 1 - (STAGE * DIV_STEPS + j);
      nb = (k >= T_FRAC) ? w.n[(k >= T_FRAC) ? (k - T_FRAC) : 0] : 1'b0;
      trial = {w.r, nb};
      if (trial >= {1'b0, w.d}) begin
        w.r = DEN_W'(trial - {1'b0, w.d});
        w.q = w.q | (T_W'(1) << k);
      end else begin
        w.r = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
    out_w <= w;
  end

endmodule

### hdl/rri_back.sv
// Back end: signed t, range test, hit point, edge projections and final word.
// Depends on rri_pkg.
module rri_back (
  input  logic               clk,
  input  logic               rst,
  input  rri_pkg::cfg_t      cfg,
  input  logic               in_v,
  input  rri_pkg::div_word_t in_w,
  output logic               out_v,
  output rri_pkg::out_word_t out_w
);
  import rri_pkg::*;

  localparam int PR_W = T_W + COORD_W;
  localparam int P_W  = PR_W - T_FRAC + 1;
  localparam int D_W  = P_W + 1;
  localparam int DP_W = D_W + COORD_W;
  localparam int S_W  = DP_W + 2;

  localparam logic signed [T_W-1:0] T_POS = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_NEG = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [P_W-1:0] C_HI  = P_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [P_W-1:0] C_LO  = -C_HI - P_W'(1);

  function automatic coord_t sat_coord(input logic signed [P_W-1:0] v);
    if (v > C_HI) begin
      return coord_t'(C_HI);
    end else if (v < C_LO) begin
      return coord_t'(C_LO);
    end
    return coord_t'(v);
  endfunction

  logic signed [T_W-1:0] t;
  logic                  range_miss;

  always_comb begin
    if (in_w.side.sat) begin
      t = in_w.side.neg ? T_NEG : T_POS;
    end else begin
      t = in_w.side.neg ? -$signed(in_w.q) : $signed(in_w.q);
    end
    if (in_w.side.mode) begin
      range_miss = (t <= EPS_T);
    end else begin
      range_miss = (t < in_w.side.t_lower) || (t > in_w.side.t_upper);
    end
  end

  logic                  e_v, e_miss;
  logic signed [T_W-1:0] e_t;
  vec3_t                 e_o, e_d;

  logic                  f_v, f_miss;
  logic signed [T_W-1:0] f_t;
  vec3_t                 f_o;
  logic signed [PR_W-1:0] f_prod [3];

  logic                  g_v, g_miss;
  logic signed [T_W-1:0] g_t;
  logic signed [P_W-1:0] g_p [3];

  logic                  h_v, h_miss;
  logic signed [T_W-1:0] h_t;
  coord_t                h_pt [3];
  logic signed [D_W-1:0] h_d [3];

  logic                   i_v, i_miss;
  logic signed [T_W-1:0]  i_t;
  coord_t                 i_pt [3];
  logic signed [DP_W-1:0] i_pa [3];
  logic signed [DP_W-1:0] i_pb [3];

  logic                  j_v, j_miss;
  logic signed [T_W-1:0] j_t;
  coord_t                j_pt [3];
  logic signed [S_W-1:0] j_da, j_db;

  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else begin
      e_v <= in_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
    end
    e_miss <= in_w.side.miss || range_miss;
    e_t    <= t;
    e_o    <= in_w.side.origin;
    e_d    <= in_w.side.dir;

    f_miss <= e_miss;
    f_t    <= e_t;
    f_o    <= e_o;
    for (int i = 0; i < 3; i++) begin
      f_prod[i] <= PR_W'(e_t) * PR_W'($signed(e_d[i]));
    end

    g_miss <= f_miss;
    g_t    <= f_t;
    for (int i = 0; i < 3; i++) begin
      // arithmetic shift floors toward minus infinity
      g_p[i] <= P_W'($signed(f_o[i])) + P_W'(f_prod[i] >>> T_FRAC);
    end

    h_miss <= g_miss;
    h_t    <= g_t;
    for (int i = 0; i < 3; i++) begin
      h_pt[i] <= sat_coord(g_p[i]);
      h_d[i]  <= D_W'(g_p[i]) - D_W'($signed(cfg.corner[i]));
    end

    i_miss <= h_miss;
    i_t    <= h_t;
    for (int i = 0; i < 3; i++) begin
      i_pt[i] <= h_pt[i];
      i_pa[i] <= DP_W'(h_d[i]) * DP_W'($signed(cfg.edge_a[i]));
      i_pb[i] <= DP_W'(h_d[i]) * DP_W'($signed(cfg.edge_b[i]));
    end

    j_miss <= i_miss;
    j_t    <= i_t;
    for (int i = 0; i < 3; i++) begin
      j_pt[i] <= i_pt[i];
    end
    j_da <= S_W'(i_pa[0]) + S_W'(i_pa[1]) + S_W'(i_pa[2]);
    j_db <= S_W'(i_pb[0]) + S_W'(i_pb[1]) + S_W'(i_pb[2]);
  end

  always_comb begin
    hit = !j_miss
       && (j_da >= 0) && (j_da <= $signed(S_W'(cfg.len_a)))
       && (j_db >= 0) && (j_db <= $signed(S_W'(cfg.len_b)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= j_v;
    end
    out_w.hit     <= hit;
    out_w.hit_t   <= hit ? j_t : '0;
    out_w.point_x <= hit ? j_pt[0] : '0;
    out_w.point_y <= hit ? j_pt[1] : '0;
    out_w.point_z <= hit ? j_pt[2] : '0;
  end

endmodule

### hdl/rri_fifo.sv
// Result buffer behind the pipeline; absorbs words while the sink stalls.
// Depends on rri_pkg.
module rri_fifo #(
  parameter int DEPTH = rri_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_v,
  input  rri_pkg::out_word_t wr_w,
  input  logic               rd_ready,
  output logic               rd_v,
  output rri_pkg::out_word_t rd_w
);
  import rri_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             rd_fire;

  assign rd_v    = (count != '0);
  assign rd_w    = mem[rd_ptr];
  assign rd_fire = rd_v && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_v) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_v) - CNT_W'(rd_fire);
    end
    if (wr_v) begin
      mem[wr_ptr] <= wr_w;
    end
  end

endmodule

### hdl/ray_rectangle_intersect_core.sv
// Top level of the ray / rectangle intersection core: config registers,
// credit control, pipeline and result buffer. Depends on rri_pkg and all rri_ modules.
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index (register), cfg_data
//  in      | in_valid/in_ready    | in_data  : mode, origin, dir, t range
//  out     | out_valid/out_ready  | out_data : hit, hit_t, point x/y/z
//
// One ray enters per cycle while in_ready is high. The pipeline has 4 front
// stages, 16 divider stages of two quotient bits and 7 back stages, followed
// by the result buffer; the restoring divider sets most of that depth.
// The pipeline never stalls: a credit count of words in flight plus words
// buffered holds in_ready low once the 32-entry result buffer could fill.
// Reset (rst, synchronous) clears the config registers and credit count to zero and empties the pipe.
// cfg_ready is always high.
module ray_rectangle_intersect_core #(
  parameter int DEPTH = rri_pkg::FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rri_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rri_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rri_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rri_pkg::out_word_t              out_data
);
  import rri_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CORNER: cfg.corner <= cfg_data;
        REG_EDGE_A: cfg.edge_a <= cfg_data;
        REG_EDGE_B: cfg.edge_b <= cfg_data;
        REG_NORMAL: cfg.normal <= cfg_data;
        REG_LEN_A:  cfg.len_a  <= cfg_data[LEN_W-1:0];
        REG_LEN_B:  cfg.len_b  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // credits: words accepted but not yet delivered
  logic [CNT_W-1:0] credit;
  logic             in_fire, out_fire;

  assign in_ready = (credit < CNT_W'(DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CNT_W'(in_fire) - CNT_W'(out_fire);
    end
  end

  logic      front_v;
  div_word_t front_w;

  rri_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_v  (in_fire),
    .in_w  (in_data),
    .out_v (front_v),
    .out_w (front_w)
  );

  logic      div_v [DIV_STAGES+1];
  div_word_t div_w [DIV_STAGES+1];

  assign div_v[0] = front_v;
  assign div_w[0] = front_w;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rri_div_stage #(.STAGE(s)) u_div (
      .clk   (clk),
      .rst   (rst),
      .in_v  (div_v[s]),
      .in_w  (div_w[s]),
      .out_v (div_v[s+1]),
      .out_w (div_w[s+1])
    );
  end

  logic      back_v;
  out_word_t back_w;

  rri_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_v  (div_v[DIV_STAGES]),
    .in_w  (div_w[DIV_STAGES]),
    .out_v (back_v),
    .out_w (back_w)
  );

  rri_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_v     (back_v),
    .wr_w     (back_w),
    .rd_ready (out_ready),
    .rd_v     (out_valid),
    .rd_w     (out_data)
  );

endmodule
